FILE: sv/vat_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the vertex affine transform block.
package vat_pkg;

  localparam int COORD_W    = 32;
  localparam int TRIG_W     = 18;
  localparam int TRIG_BITS  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] MODE_TRANSLATE = 3'd0;
  localparam logic [2:0] MODE_SCALE     = 3'd1;
  localparam logic [2:0] MODE_ROT_X     = 3'd2;
  localparam logic [2:0] MODE_ROT_Y     = 3'd3;
  localparam logic [2:0] MODE_ROT_Z     = 3'd4;
  localparam logic [2:0] MODE_CENTER    = 3'd5;
  localparam logic [2:0] MODE_NORMALIZE = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN    = 3'd5;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_APPLY   = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] axis;
    coord_t     offset;
    coord_t     scale;
    trig_t      cos_v;
    trig_t      sin_v;
  } cfg_t;

  // One apply item on its way from the front to the back, with the bounding
  // box figures it needs taken at the moment it was accepted.
  typedef struct packed {
    coord_t [2:0] v;
    coord_t [2:0] mid;
    logic [31:0]  ext;
    logic         need_factor;
  } entry_t;

  function automatic coord_t sat32(input logic signed [63:0] x);
    if (x > $signed(64'h0000_0000_7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end
    if (x < $signed(64'hFFFF_FFFF_8000_0000)) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [63:0] sext64(input coord_t x);
    return $signed({{32{x[31]}}, x});
  endfunction

endpackage

FILE: sv/vat_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, keeps the bounding box and classifies apply items.
module vat_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  logic            in_op,
  input  logic            in_first,
  input  vat_pkg::coord_t in_x_in,
  input  vat_pkg::coord_t in_y_in,
  input  vat_pkg::coord_t in_z_in,
  input  logic [2:0]      mode,
  input  logic            q_full,
  output logic            q_push,
  output vat_pkg::entry_t q_entry
);

  vat_pkg::coord_t min_r [3];
  vat_pkg::coord_t max_r [3];
  vat_pkg::coord_t min_nxt [3];
  vat_pkg::coord_t max_nxt [3];
  vat_pkg::coord_t vtx [3];
  logic            ready_r;
  logic            ready_nxt;
  logic            accept;
  logic            need_factor;
  logic [32:0]     sum_c [3];
  logic [32:0]     diff_c [3];
  logic [31:0]     ext_c;

  always_comb begin
    vtx[0] = in_x_in;
    vtx[1] = in_y_in;
    vtx[2] = in_z_in;
    accept = in_push && !q_full;
    need_factor = (in_op == vat_pkg::OP_APPLY) && (mode == vat_pkg::MODE_NORMALIZE) &&
                  (in_first || !ready_r);
    ext_c = '0;
    for (int i = 0; i < 3; i++) begin
      sum_c[i]  = {max_r[i][31], max_r[i]} + {min_r[i][31], min_r[i]};
      diff_c[i] = {max_r[i][31], max_r[i]} - {min_r[i][31], min_r[i]};
      if (!diff_c[i][32] && (diff_c[i][31:0] > ext_c)) begin
        ext_c = diff_c[i][31:0];
      end
    end
    ready_nxt = ready_r;
    for (int i = 0; i < 3; i++) begin
      min_nxt[i] = min_r[i];
      max_nxt[i] = max_r[i];
    end
    if (accept) begin
      if (in_op == vat_pkg::OP_MEASURE) begin
        for (int i = 0; i < 3; i++) begin
          if (in_first) begin
            min_nxt[i] = vtx[i];
            max_nxt[i] = vtx[i];
          end else begin
            if (vtx[i] < min_r[i]) min_nxt[i] = vtx[i];
            if (vtx[i] > max_r[i]) max_nxt[i] = vtx[i];
          end
        end
        ready_nxt = 1'b0;
      end else if (need_factor) begin
        ready_nxt = 1'b1;
      end
    end
    q_push = accept && (in_op == vat_pkg::OP_APPLY);
    for (int i = 0; i < 3; i++) begin
      q_entry.v[i]   = vtx[i];
      q_entry.mid[i] = sum_c[i][32:1];
    end
    q_entry.ext = ext_c;
    q_entry.need_factor = need_factor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= '0;
        max_r[i] <= '0;
      end
    end else begin
      ready_r <= ready_nxt;
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= min_nxt[i];
        max_r[i] <= max_nxt[i];
      end
    end
  end

endmodule

FILE: sv/vat_queue.sv
`timescale 1ns / 1ps
// Small register queue that decouples the front end from the back end.
module vat_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full    = (cnt_r == CNT_W'(DEPTH));
    empty   = (cnt_r == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    dout    = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: sv/vat_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the normalize factor.
module vat_div #(
  parameter int NUM_W = 34
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [31:0]      den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc_r;
  logic [31:0]      rem_r;
  logic [31:0]      den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [32:0]      shifted;
  logic [32:0]      trial;
  logic             fits;

  always_comb begin
    shifted = {rem_r, acc_r[NUM_W-1]};
    trial   = shifted - {1'b0, den_r};
    fits    = (shifted >= {1'b0, den_r});
    done    = done_r;
    quot    = acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        acc_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= CNT_W'(NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= {acc_r[NUM_W-2:0], fits};
        rem_r <= fits ? trial[31:0] : shifted[31:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/vat_back.sv
`timescale 1ns / 1ps
// Back end: sequences the factor division, the products and the result register.
module vat_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  vat_pkg::cfg_t   cfg,
  input  logic            q_empty,
  input  vat_pkg::entry_t q_head,
  output logic            q_pop,
  input  logic            out_pop,
  output logic            out_empty,
  output vat_pkg::coord_t out_x_out,
  output vat_pkg::coord_t out_y_out,
  output vat_pkg::coord_t out_z_out,
  output logic            out_status
);

  localparam int NUM_W = (2 * FRAC_BITS + 2 > 33) ? 2 * FRAC_BITS + 2 : 33;
  localparam logic [NUM_W-1:0] K_VAL = NUM_W'(((16 << FRAC_BITS) + 5) / 10);
  localparam logic signed [63:0] HALF_F = 64'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [63:0] HALF_T = 64'(64'd1 << (vat_pkg::TRIG_BITS - 1));
  localparam vat_pkg::coord_t ONE_F = 32'(64'd1 << FRAC_BITS);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_FIN} state_t;

  state_t               state_r;
  vat_pkg::entry_t      work_r;
  vat_pkg::coord_t      norm_factor_r;
  logic signed [63:0]   pa_r [3];
  logic signed [49:0]   pb_r [3];
  logic                 out_valid_r;
  vat_pkg::coord_t      out_r [3];
  logic                 status_r;

  vat_pkg::coord_t      vw [3];
  vat_pkg::coord_t      mw [3];
  vat_pkg::coord_t      oth [3];
  vat_pkg::coord_t      op_a;
  vat_pkg::coord_t      k_eff;
  vat_pkg::coord_t      sin_ext;
  logic signed [63:0]   pa_c [3];
  logic signed [49:0]   pb_c [3];
  logic                 rot_use [3];
  logic                 rot_sub [3];
  logic signed [63:0]   rsum [3];
  logic signed [63:0]   rscaled [3];
  logic signed [63:0]   rrot [3];
  vat_pkg::coord_t      res [3];
  logic                 res_status;
  logic                 div_start;
  logic [NUM_W-1:0]     div_num;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quot;
  vat_pkg::coord_t      quot_sat;
  logic                 slot_free;

  vat_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (q_head.ext),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    q_pop     = (state_r == S_IDLE) && !q_empty;
    div_start = q_pop && q_head.need_factor && (q_head.ext != '0);
    div_num   = (K_VAL << FRAC_BITS) + NUM_W'(q_head.ext >> 1);
    quot_sat  = (|div_quot[NUM_W-1:31]) ? 32'sh7FFF_FFFF : {1'b0, div_quot[30:0]};
    slot_free = !out_valid_r || out_pop;

    for (int i = 0; i < 3; i++) begin
      vw[i]      = work_r.v[i];
      mw[i]      = work_r.mid[i];
      oth[i]     = vw[i];
      rot_use[i] = 1'b0;
      rot_sub[i] = 1'b0;
    end
    unique case (cfg.mode)
      vat_pkg::MODE_ROT_X: begin
        oth[1] = vw[2]; oth[2] = vw[1];
        rot_use[1] = 1'b1; rot_use[2] = 1'b1; rot_sub[1] = 1'b1;
      end
      vat_pkg::MODE_ROT_Y: begin
        oth[0] = vw[2]; oth[2] = vw[0];
        rot_use[0] = 1'b1; rot_use[2] = 1'b1; rot_sub[2] = 1'b1;
      end
      vat_pkg::MODE_ROT_Z: begin
        oth[0] = vw[1]; oth[1] = vw[0];
        rot_use[0] = 1'b1; rot_use[1] = 1'b1; rot_sub[0] = 1'b1;
      end
      default: begin
      end
    endcase

    // A zero scale factor behaves as one.
    k_eff   = (cfg.scale == '0) ? ONE_F : cfg.scale;
    sin_ext = {{14{cfg.sin_v[17]}}, cfg.sin_v};
    unique case (cfg.mode)
      vat_pkg::MODE_SCALE:     op_a = k_eff;
      vat_pkg::MODE_NORMALIZE: op_a = norm_factor_r;
      default:                 op_a = {{14{cfg.cos_v[17]}}, cfg.cos_v};
    endcase

    for (int i = 0; i < 3; i++) begin
      pa_c[i] = vat_pkg::sext64(vw[i]) * vat_pkg::sext64(op_a);
      pb_c[i] = $signed({{18{oth[i][31]}}, oth[i]}) * $signed({{18{sin_ext[31]}}, sin_ext});
      rsum[i] = rot_sub[i] ? pa_r[i] - 64'(pb_r[i]) : pa_r[i] + 64'(pb_r[i]);
      rscaled[i] = (pa_r[i] + HALF_F) >>> FRAC_BITS;
      rrot[i]    = (rsum[i] + HALF_T) >>> vat_pkg::TRIG_BITS;
    end

    res_status = (cfg.mode == vat_pkg::MODE_NORMALIZE) && (norm_factor_r == '0);
    for (int i = 0; i < 3; i++) begin
      unique case (cfg.mode)
        vat_pkg::MODE_TRANSLATE: begin
          res[i] = (cfg.axis == 2'(i)) ?
                   vat_pkg::sat32(vat_pkg::sext64(vw[i]) + vat_pkg::sext64(cfg.offset)) :
                   vw[i];
        end
        vat_pkg::MODE_SCALE: res[i] = vat_pkg::sat32(rscaled[i]);
        vat_pkg::MODE_ROT_X,
        vat_pkg::MODE_ROT_Y,
        vat_pkg::MODE_ROT_Z: res[i] = rot_use[i] ? vat_pkg::sat32(rrot[i]) : vw[i];
        vat_pkg::MODE_CENTER: begin
          res[i] = vat_pkg::sat32(vat_pkg::sext64(vw[i]) - vat_pkg::sext64(mw[i]));
        end
        vat_pkg::MODE_NORMALIZE: res[i] = res_status ? vw[i] : vat_pkg::sat32(rscaled[i]);
        default: res[i] = vw[i];
      endcase
    end

    out_empty  = !out_valid_r;
    out_x_out  = out_r[0];
    out_y_out  = out_r[1];
    out_z_out  = out_r[2];
    out_status = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      norm_factor_r <= '0;
    end else begin
      if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            work_r <= q_head;
            if (div_start) begin
              state_r <= S_DIV;
            end else begin
              if (q_head.need_factor) begin
                norm_factor_r <= '0;
              end
              state_r <= S_MUL;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            norm_factor_r <= quot_sat;
            state_r       <= S_MUL;
          end
        end
        S_MUL: begin
          for (int i = 0; i < 3; i++) begin
            pa_r[i] <= pa_c[i];
            pb_r[i] <= pb_c[i];
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            for (int i = 0; i < 3; i++) begin
              out_r[i] <= res[i];
            end
            status_r    <= res_status;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/vertex_affine_transform_core.sv
`timescale 1ns / 1ps
// Top level of the vertex affine transform: configuration registers and the two halves.
//
// Usage. Vertices arrive on the input queue interface (in_push / in_full) with an op
// bit: a measure item widens the running bounding box and gives no result, its first
// flag restarting the box; an apply item gives one transformed vertex on the result
// queue interface (out_empty / out_pop), in the mode held in the configuration
// registers. Configuration is written through cfg_we / cfg_index / cfg_data while the
// block is idle; a write to an index beyond the register list is ignored.
// Timing. Measure items are taken one per cycle while the internal queue is not full.
// Each apply item passes through a QUEUE_DEPTH-entry queue (two by default) into the
// back end, which takes it, multiplies, then rounds and saturates into the result
// register, and takes the next item only once it is done with the last one. The first
// normalize item of a pass also runs the factor division before its products, one
// quotient bit a cycle; the factor is Q16.16 at the default FRAC_BITS.
// Reset. A synchronous low rst_n clears the bounding box, the factor and all queues,
// and returns the registers to translate on x by zero with unit scale and no rotation.
// Stalls. A result waits in the output register until it is popped; meanwhile the
// front keeps accepting items until the internal queue is full, and then raises in_full.
module vertex_affine_transform_core #(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic                             in_op,
  input  logic                             in_first,
  input  vat_pkg::coord_t                  in_x_in,
  input  vat_pkg::coord_t                  in_y_in,
  input  vat_pkg::coord_t                  in_z_in,
  output logic                             out_empty,
  input  logic                             out_pop,
  output vat_pkg::coord_t                  out_x_out,
  output vat_pkg::coord_t                  out_y_out,
  output vat_pkg::coord_t                  out_z_out,
  output logic                             out_status,
  input  logic                             cfg_we,
  input  logic [vat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vat_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ENTRY_W = $bits(vat_pkg::entry_t);

  vat_pkg::cfg_t   cfg_r;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  vat_pkg::entry_t q_entry;
  vat_pkg::entry_t q_head;
  logic [ENTRY_W-1:0] q_dout;

  // Configuration registers. Each write replaces one register whole; the block reads
  // them live, so a write also changes items already in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= vat_pkg::MODE_TRANSLATE;
      cfg_r.axis   <= '0;
      cfg_r.offset <= '0;
      cfg_r.scale  <= 32'(64'd1 << FRAC_BITS);
      cfg_r.cos_v  <= 18'sd65536;
      cfg_r.sin_v  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vat_pkg::CFG_MODE:   cfg_r.mode   <= cfg_data[2:0];
        vat_pkg::CFG_AXIS:   cfg_r.axis   <= cfg_data[1:0];
        vat_pkg::CFG_OFFSET: cfg_r.offset <= cfg_data;
        vat_pkg::CFG_SCALE:  cfg_r.scale  <= cfg_data;
        vat_pkg::CFG_COS:    cfg_r.cos_v  <= cfg_data[17:0];
        vat_pkg::CFG_SIN:    cfg_r.sin_v  <= cfg_data[17:0];
        default: begin
        end
      endcase
    end
  end

  // The front end takes every item unless the queue is full; measure items end there.
  vat_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_op    (in_op),
    .in_first (in_first),
    .in_x_in  (in_x_in),
    .in_y_in  (in_y_in),
    .in_z_in  (in_z_in),
    .mode     (cfg_r.mode),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  // Apply items carry a snapshot of the bounding box figures, so later measure items
  // cannot disturb the ones still waiting here.
  vat_queue #(
    .W     (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_entry),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_head  = q_dout;
  assign in_full = q_full;

  // The back end works on one apply item at a time and owns the result register.
  vat_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_x_out  (out_x_out),
    .out_y_out  (out_y_out),
    .out_z_out  (out_z_out),
    .out_status (out_status)
  );

endmodule
